@@ rtl/hrpd_pkg.sv @@
// ----------------------------------------------------------------------------
// hrpd_pkg: shared types and constants for the heart rate peak detector
// Holds the payload structs of both channels, configuration register indexes
// and reset values, and the fixed widths of the data path.
// ----------------------------------------------------------------------------
package hrpd_pkg;

  // Field widths.
  localparam int SAMPLE_BITS = 12;
  localparam int TIME_W      = 32;
  localparam int RATE_W      = 16;

  // Rate numerator: 60000 ms per minute in Q8.8, and its width.
  localparam int          NUM_W          = 24;
  localparam logic [23:0] RATE_NUMERATOR = 24'd15360000;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INACTIVITY   = 2'd3;

  // Configuration reset values.
  localparam logic [SAMPLE_BITS-1:0] NOISE_FLOOR_RST  = 12'd500;
  localparam logic [15:0]            MIN_INTERVAL_RST = 16'd300;
  localparam logic [15:0]            MAX_HOLD_RST     = 16'd2000;
  localparam logic [15:0]            INACTIVITY_RST   = 16'd4000;

  // Input transaction.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_W-1:0]      time_ms;
  } sample_t;

  // Output transaction.
  typedef struct packed {
    logic [RATE_W-1:0] average_rate;
    logic [RATE_W-1:0] instant_rate;
    logic              beat_found;
  } result_t;

endpackage

@@ rtl/heart_rate_peak_detector.sv @@
// ----------------------------------------------------------------------------
// heart_rate_peak_detector: adaptive threshold R-peak detector with rate ring
// Tracks the ECG maximum, detects rising threshold crossings, converts the
// beat interval to a Q8.8 rate and averages the last RING_DEPTH rates.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel (smp_valid/smp_stall/smp_data) carries one ECG sample
//   with its millisecond timestamp per transaction. Every sample yields one
//   result transaction on the rate channel (rate_valid/rate_stall/rate_data):
//   average rate, instant rate and a beat flag.
//   The block works on one sample at a time. From acceptance to result a
//   sample passes through evaluation, then, when it gives a beat, the beat
//   rate division and the ring push, then the sum over the filled ring
//   entries and, unless the ring is still empty, the average division. The
//   bit serial divider (one quotient bit per cycle, run for the beat rate and
//   again for the average) and the one-entry-per-cycle ring sum set its pace.
//   A finished result sits in an output register; the next sample is taken
//   while it waits, and a stalled receiver holds the block only when the
//   following result is ready.
//   Synchronous reset restores the configuration defaults, clears the
//   detector state and empties the ring; the ring storage itself is not
//   cleared. Configuration writes are taken at any edge with cfg_wr_en high outside reset.
// ----------------------------------------------------------------------------
module heart_rate_peak_detector #(
  parameter int RING_DEPTH = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // Sample channel
  input  logic                                smp_valid,
  output logic                                smp_stall,
  input  hrpd_pkg::sample_t                   smp_data,
  // Result channel
  output logic                                rate_valid,
  input  logic                                rate_stall,
  output hrpd_pkg::result_t                   rate_data,
  // Configuration port
  input  logic                                cfg_wr_en,
  input  logic [hrpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hrpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SB     = hrpd_pkg::SAMPLE_BITS;
  localparam int TW     = hrpd_pkg::TIME_W;
  localparam int RW     = hrpd_pkg::RATE_W;
  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = RW + CNT_W;
  localparam int DIV_W  = (SUM_W > hrpd_pkg::NUM_W) ? SUM_W : hrpd_pkg::NUM_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

  // State codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_RDIV = 3'd2;
  localparam logic [2:0] ST_PUSH = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_ADIV = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // Configuration registers
  logic [SB-1:0] noise_floor;
  logic [15:0]   min_interval_ms;
  logic [15:0]   max_hold_ms;
  logic [15:0]   inactivity_ms;

  // Detector state
  logic [2:0]    state;
  logic [SB-1:0] cur_sample;
  logic [TW-1:0] cur_time;
  logic [SB-1:0] tracked_max;
  logic [SB-1:0] threshold_base;
  logic [SB-1:0] previous_sample;
  logic [TW-1:0] last_peak_time;
  logic [TW-1:0] last_clear_time;
  logic [RW-1:0] current_rate;
  logic [IDX_W-1:0] ring_index;
  logic          ring_full;
  logic          beat;

  // Ring storage and sum
  logic [RW-1:0]    ring [RING_DEPTH];
  logic             ring_we;
  logic [RW-1:0]    ring_wdata;
  logic [RW-1:0]    rd_data;
  logic             rd_pend;
  logic [CNT_W-1:0] rd_k;
  logic [IDX_W-1:0] rd_addr;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;

  // Shared bit serial divider
  logic [DIV_W-1:0]  div_q;
  logic [TW-1:0]     div_r;
  logic [TW-1:0]     div_d;
  logic [DCNT_W-1:0] div_cnt;
  logic [TW:0]       div_trial;
  logic              div_ge;
  logic [TW:0]       div_diff;
  logic              avg_zero;

  // Evaluation of one sample
  logic [TW-1:0] since_peak;
  logic [TW-1:0] since_clear;
  logic          do_clear;
  logic [SB-1:0] max_after_clear;
  logic          rise;
  logic [SB-1:0] base_new;
  logic          inact;
  logic          peak;
  logic [RW-1:0] sat_rate;
  logic [IDX_W-1:0] idx_adv;
  logic          wrap;

  // Exact test of x > 0.8 * base, written as 5x > 4base.
  function automatic logic above_thr(input logic [SB-1:0] x, input logic [SB-1:0] base);
    logic [SB+2:0] lhs;
    logic [SB+2:0] rhs;
    lhs = {1'b0, x, 2'b00} + {3'b000, x};
    rhs = {1'b0, base, 2'b00};
    return lhs > rhs;
  endfunction

  assign smp_stall = (state != ST_IDLE);

  // Clear, rise, inactivity and peak decisions for the held sample.
  always_comb begin
    since_peak      = cur_time - last_peak_time;
    since_clear     = cur_time - last_clear_time;
    do_clear        = (since_peak > {16'd0, max_hold_ms}) && (tracked_max != '0) &&
                      (since_clear > {16'd0, max_hold_ms});
    max_after_clear = do_clear ? '0 : tracked_max;
    rise            = cur_sample > max_after_clear;
    base_new        = rise ? cur_sample : threshold_base;
    inact           = since_peak > {16'd0, inactivity_ms};
    peak            = above_thr(cur_sample, base_new) && (cur_sample > noise_floor) &&
                      !above_thr(previous_sample, base_new) &&
                      (since_peak > {16'd0, min_interval_ms});
  end

  // Ring pointer advance.
  assign wrap    = (ring_index == LAST_IDX);
  assign idx_adv = wrap ? '0 : ring_index + 1'b1;

  // Divider step: one quotient bit per cycle.
  always_comb begin
    div_trial = {div_r, div_q[DIV_W-1]};
    div_ge    = div_trial >= {1'b0, div_d};
    div_diff  = div_trial - {1'b0, div_d};
  end

  // Rate saturated to 16 bits.
  assign sat_rate = (|div_q[DIV_W-1:RW]) ? {RW{1'b1}} : div_q[RW-1:0];

  // Ring write port: inactivity zero during evaluation, beat rate afterward.
  always_comb begin
    ring_we    = 1'b0;
    ring_wdata = '0;
    if (state == ST_EVAL && inact) begin
      ring_we = 1'b1;
    end else if (state == ST_PUSH) begin
      ring_we    = 1'b1;
      ring_wdata = sat_rate;
    end
  end

  // Filled entries and read address for the running sum.
  assign count   = ring_full ? DEPTH_CNT : CNT_W'(ring_index);
  assign rd_addr = (rd_k < count) ? rd_k[IDX_W-1:0] : '0;

  // Ring memory with registered read.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_index] <= ring_wdata;
    end
    rd_data <= ring[rd_addr];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_floor     <= hrpd_pkg::NOISE_FLOOR_RST;
      min_interval_ms <= hrpd_pkg::MIN_INTERVAL_RST;
      max_hold_ms     <= hrpd_pkg::MAX_HOLD_RST;
      inactivity_ms   <= hrpd_pkg::INACTIVITY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hrpd_pkg::CFG_NOISE_FLOOR:  noise_floor     <= cfg_wdata[SB-1:0];
        hrpd_pkg::CFG_MIN_INTERVAL: min_interval_ms <= cfg_wdata;
        hrpd_pkg::CFG_MAX_HOLD:     max_hold_ms     <= cfg_wdata;
        hrpd_pkg::CFG_INACTIVITY:   inactivity_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Payload registers: held sample, divider and sum data path.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && smp_valid) begin
      cur_sample <= smp_data.sample;
      cur_time   <= smp_data.time_ms;
    end
    unique case (state) inside
      ST_EVAL: begin
        div_q <= DIV_W'(hrpd_pkg::RATE_NUMERATOR);
        div_d <= since_peak;
        div_r <= '0;
        sum   <= '0;
      end
      ST_RDIV, ST_ADIV: begin
        div_q <= {div_q[DIV_W-2:0], div_ge};
        div_r <= div_ge ? div_diff[TW-1:0] : div_trial[TW-1:0];
      end
      ST_PUSH: begin
        sum <= '0;
      end
      ST_SUM: begin
        if (rd_pend) begin
          sum <= sum + SUM_W'(rd_data);
        end
        if (rd_k == count && !rd_pend) begin
          div_q <= DIV_W'(sum);
          div_d <= TW'(count);
          div_r <= '0;
        end
      end
      default: ;
    endcase
  end

  // Control state machine and detector state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      tracked_max     <= '0;
      threshold_base  <= '0;
      previous_sample <= '0;
      last_peak_time  <= '0;
      last_clear_time <= '0;
      current_rate    <= '0;
      ring_index      <= '0;
      ring_full       <= 1'b0;
      beat            <= 1'b0;
      rd_pend         <= 1'b0;
      rd_k            <= '0;
      div_cnt         <= '0;
      avg_zero        <= 1'b0;
      rate_valid      <= 1'b0;
    end else begin
      // A waiting result leaves once the receiver takes it, unless the next
      // one replaces it at the same edge.
      if (rate_valid && !rate_stall && state != ST_DONE) begin
        rate_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (smp_valid) begin
            state <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          if (do_clear) begin
            last_clear_time <= cur_time;
          end
          tracked_max     <= rise ? cur_sample : max_after_clear;
          threshold_base  <= base_new;
          previous_sample <= cur_sample;
          beat            <= peak;
          if (inact) begin
            current_rate <= '0;
            ring_index   <= idx_adv;
            if (wrap) begin
              ring_full <= 1'b1;
            end
          end
          rd_k    <= '0;
          rd_pend <= 1'b0;
          div_cnt <= DCNT_W'(DIV_W);
          state   <= peak ? ST_RDIV : ST_SUM;
        end

        ST_RDIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= ST_PUSH;
          end
        end

        ST_PUSH: begin
          current_rate   <= sat_rate;
          last_peak_time <= cur_time;
          ring_index     <= idx_adv;
          if (wrap) begin
            ring_full <= 1'b1;
          end
          rd_k    <= '0;
          rd_pend <= 1'b0;
          state   <= ST_SUM;
        end

        ST_SUM: begin
          // Issue one read per cycle and add the previous one.
          rd_pend <= (rd_k < count);
          if (rd_k < count) begin
            rd_k <= rd_k + 1'b1;
          end
          if (rd_k == count && !rd_pend) begin
            avg_zero <= (count == '0);
            div_cnt  <= DCNT_W'(DIV_W);
            state    <= (count == '0) ? ST_DONE : ST_ADIV;
          end
        end

        ST_ADIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!rate_valid || !rate_stall) begin
            rate_valid <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rate_valid || !rate_stall)) begin
      rate_data.average_rate <= avg_zero ? '0 : div_q[RW-1:0];
      rate_data.instant_rate <= current_rate;
      rate_data.beat_found   <= beat;
    end
  end

endmodule

@@ dv/heart_rate_peak_detector_test.sv @@
// ----------------------------------------------------------------------------
// heart_rate_peak_detector_test: self-checking bench for the peak detector
// Feeds ECG-like sample streams with random handshake gaps, predicts every
// result with an independent model of the detector and the rate ring, and
// compares each result field by field. Configuration changes between phases
// cover the register extremes, and one long receiver hold backs up the block.
// ----------------------------------------------------------------------------
module heart_rate_peak_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH   = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_REPORTS  = 60;

  localparam int SB = hrpd_pkg::SAMPLE_BITS;
  localparam int TW = hrpd_pkg::TIME_W;
  localparam int RW = hrpd_pkg::RATE_W;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            smp_valid = 1'b0;
  logic                            smp_stall;
  hrpd_pkg::sample_t               smp_data = '0;
  logic                            rate_valid;
  logic                            rate_stall = 1'b0;
  hrpd_pkg::result_t               rate_data;
  logic                            cfg_wr_en = 1'b0;
  logic [hrpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hrpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  heart_rate_peak_detector #(
    .RING_DEPTH(RING_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp_data  (smp_data),
    .rate_valid(rate_valid),
    .rate_stall(rate_stall),
    .rate_data (rate_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the configuration registers.
  logic [SB-1:0] noise_floor_q;
  logic [15:0]   min_interval_q;
  logic [15:0]   max_hold_q;
  logic [15:0]   inactivity_q;

  // Detector state as the block should hold it.
  logic [SB-1:0] peak_max;
  logic [SB-1:0] thresh_base;
  logic [SB-1:0] last_sample;
  logic [TW-1:0] last_beat_ms;
  logic [TW-1:0] last_clear_ms;
  logic [RW-1:0] rate_hist [RING_DEPTH];
  int unsigned   hist_wr;
  bit            hist_full;
  logic [RW-1:0] beat_rate;

  // Queues and counters shared by the stimulus, driver and monitor.
  hrpd_pkg::sample_t sample_backlog [$];
  hrpd_pkg::result_t rate_expected [$];
  int unsigned items_queued;
  int unsigned samples_sent;
  int unsigned results_checked;
  int unsigned beats_seen;
  int unsigned mismatches;
  int unsigned settings_used;
  int unsigned cycle_count;
  bit          quiet_tail;
  logic [TW-1:0] stim_ms;

  // The threshold is 0.8 of the base, compared exactly as 5x > 4*base.
  function automatic bit over_threshold(logic [SB-1:0] x);
    return (32'(x) * 32'd5) > (32'(thresh_base) * 32'd4);
  endfunction

  function automatic void push_rate(logic [RW-1:0] r);
    rate_hist[hist_wr] = r;
    hist_wr++;
    if (hist_wr == RING_DEPTH) begin
      hist_wr   = 0;
      hist_full = 1'b1;
    end
  endfunction

  // Advance the detector by one sample and return the result it must produce.
  function automatic hrpd_pkg::result_t predict_rate(hrpd_pkg::sample_t item);
    logic [TW-1:0]     since_beat;
    logic [TW-1:0]     since_clear;
    logic [31:0]       quotient;
    logic [31:0]       total;
    int unsigned       fill;
    hrpd_pkg::result_t res;
    res         = '0;
    since_beat  = item.time_ms - last_beat_ms;
    since_clear = item.time_ms - last_clear_ms;

    // Forget the maximum after a long stretch without a beat.
    if (since_beat > 32'(max_hold_q) && peak_max != '0 && since_clear > 32'(max_hold_q)) begin
      peak_max      = '0;
      last_clear_ms = item.time_ms;
    end
    if (item.sample > peak_max) begin
      peak_max    = item.sample;
      thresh_base = item.sample;
    end

    // Inactivity pushes a zero rate on every sample.
    if (since_beat > 32'(inactivity_q)) begin
      beat_rate = '0;
      push_rate('0);
    end

    // Rising crossing above threshold and noise floor, outside the refractory time.
    if (over_threshold(item.sample) && item.sample > noise_floor_q &&
        !over_threshold(last_sample) && since_beat > 32'(min_interval_q)) begin
      quotient = 32'(hrpd_pkg::RATE_NUMERATOR) / since_beat;
      if (quotient > 32'hFFFF) begin
        quotient = 32'hFFFF;
      end
      beat_rate = quotient[RW-1:0];
      push_rate(beat_rate);
      last_beat_ms    = item.time_ms;
      res.beat_found  = 1'b1;
    end
    last_sample = item.sample;

    // Truncated mean over the filled ring entries.
    fill  = hist_full ? RING_DEPTH : hist_wr;
    total = '0;
    for (int k = 0; k < fill; k++) begin
      total += 32'(rate_hist[k]);
    end
    res.average_rate = (fill == 0) ? '0 : RW'(total / fill);
    res.instant_rate = beat_rate;
    return res;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS) begin
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      end
      mismatches++;
    end
  endfunction

  // Sample driver: takes the next pending transaction whenever the slot frees up and no random gap is pending.
  int unsigned send_gap;

  always @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else begin
      if (smp_valid && !smp_stall) begin
        rate_expected.push_back(predict_rate(smp_data));
        samples_sent++;
      end
      if (!smp_valid || !smp_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          smp_valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          smp_data  <= sample_backlog.pop_front();
          smp_valid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(1, 5);
          end
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold, counted in cycles, so the block backs up into
  // the sample channel.
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && results_checked >= 300) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks every accepted transaction and drives the stall.
  int unsigned stall_left;

  always @(posedge clk) begin : result_monitor
    hrpd_pkg::result_t want;
    if (rst) begin
      rate_stall <= 1'b0;
    end else begin
      if (rate_valid && !rate_stall) begin
        if (rate_expected.size() == 0) begin
          $display("%0t: result expected none, actual %p", $time, rate_data);
          mismatches++;
        end else begin
          want = rate_expected.pop_front();
          check_field("average_rate", 32'(want.average_rate), 32'(rate_data.average_rate));
          check_field("instant_rate", 32'(want.instant_rate), 32'(rate_data.instant_rate));
          check_field("beat_found", 32'(want.beat_found), 32'(rate_data.beat_found));
        end
        results_checked++;
        if (rate_data.beat_found) begin
          beats_seen++;
        end
      end

      if (hold_left > 0) begin
        rate_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rate_stall <= 1'b1;
      end else begin
        rate_stall <= 1'b0;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 5);
        end
      end
    end
  end

  task automatic queue_sample(logic [SB-1:0] s, logic [TW-1:0] t);
    hrpd_pkg::sample_t item;
    item.sample  = s;
    item.time_ms = t;
    sample_backlog.push_back(item);
    items_queued++;
    stim_ms = t;
  endtask

  // Mostly heartbeat-like streams: quiet baseline, then one sharp peak.
  // The rest is arbitrary samples, sometimes at an arbitrary timestamp.
  task automatic queue_traffic(int unsigned count);
    int unsigned stop_at;
    int unsigned span;
    int unsigned lead;
    int unsigned step;
    stop_at = items_queued + count;
    while (items_queued < stop_at) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          queue_sample(SB'($urandom_range(0, 4095)),
                       ($urandom_range(0, 7) == 0) ? $urandom() :
                                                      stim_ms + $urandom_range(0, 40));
        end
      end else begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(2000, 9000) :
                                             $urandom_range(150, 1500);
        lead = $urandom_range(1, 5);
        step = span / (lead + 1);
        repeat (lead) begin
          queue_sample(SB'($urandom_range(0, 900)), stim_ms + step);
        end
        queue_sample(($urandom_range(0, 3) == 0) ? SB'($urandom_range(600, 4095)) :
                                                   SB'($urandom_range(3300, 4095)),
                     stim_ms + step);
        // A plateau sample after the peak must not count as a new crossing.
        if ($urandom_range(0, 3) == 0) begin
          queue_sample(SB'($urandom_range(3300, 4095)), stim_ms + $urandom_range(1, 8));
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (results_checked != items_queued) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [hrpd_pkg::CFG_IDX_W-1:0] idx,
                           logic [hrpd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      hrpd_pkg::CFG_NOISE_FLOOR:  noise_floor_q  = val[SB-1:0];
      hrpd_pkg::CFG_MIN_INTERVAL: min_interval_q = val;
      hrpd_pkg::CFG_MAX_HOLD:     max_hold_q     = val;
      hrpd_pkg::CFG_INACTIVITY:   inactivity_q   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Reconfigure once the block has drained, then queue the next batch.
  task automatic run_phase(logic [15:0] noise, logic [15:0] min_gap, logic [15:0] hold,
                           logic [15:0] inact, int unsigned count);
    wait_idle();
    write_reg(hrpd_pkg::CFG_NOISE_FLOOR, noise);
    write_reg(hrpd_pkg::CFG_MIN_INTERVAL, min_gap);
    write_reg(hrpd_pkg::CFG_MAX_HOLD, hold);
    write_reg(hrpd_pkg::CFG_INACTIVITY, inact);
    settings_used++;
    queue_traffic(count);
  endtask

  // Run time guard.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    noise_floor_q  = hrpd_pkg::NOISE_FLOOR_RST;
    min_interval_q = hrpd_pkg::MIN_INTERVAL_RST;
    max_hold_q     = hrpd_pkg::MAX_HOLD_RST;
    inactivity_q   = hrpd_pkg::INACTIVITY_RST;
    peak_max       = '0;
    thresh_base    = '0;
    last_sample    = '0;
    last_beat_ms   = '0;
    last_clear_ms  = '0;
    hist_wr        = 0;
    hist_full      = 1'b0;
    beat_rate      = '0;
    settings_used  = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset configuration.
    queue_sample(12'd0, 32'd0);
    queue_sample(12'd4095, 32'd10);          // new maximum, too soon for a beat
    queue_sample(12'd0, 32'd20);
    queue_sample(12'd4095, 32'd1000);        // first beat
    queue_sample(12'd4095, 32'd1010);        // plateau, no crossing
    queue_sample(12'd0, 32'd1100);
    queue_sample(12'd4095, 32'd1300);        // interval equal to the minimum
    queue_sample(12'd0, 32'd1301);
    queue_sample(12'd4095, 32'd1301);        // one past the minimum
    queue_sample(12'd0, 32'd1400);
    queue_sample(12'd3276, 32'd1800);        // exactly at the threshold
    queue_sample(12'd0, 32'd1900);
    queue_sample(12'd3277, 32'd2000);        // just above the threshold
    queue_sample(12'd0, 32'd2100);
    queue_sample(12'd4095, 32'd9000);        // inactivity zero and a beat together
    queue_sample(12'd0, 32'hFFFF_FF00);
    queue_sample(12'd4095, 32'hFFFF_FFFF);   // huge interval gives a zero rate
    queue_sample(12'd0, 32'hFFFF_FFFF);
    queue_sample(12'd4095, 32'h0000_0200);   // interval across the timestamp wrap
    queue_sample(12'd0, 32'h0000_2000);      // maximum cleared after the hold time
    queue_sample(12'd500, 32'h0000_2100);    // equal to the noise floor
    queue_sample(12'd0, 32'h0000_2110);
    queue_sample(12'd501, 32'h0000_2120);    // just above the noise floor

    // Random phases across the register range.
    run_phase(16'd0, 16'd235, 16'd0, 16'd0, 120);
    run_phase(16'd4095, 16'd65535, 16'd65535, 16'd65535, 60);
    run_phase(16'd100, 16'd100, 16'd1000, 16'd3000, 80);    // short intervals saturate
    run_phase(16'($urandom_range(200, 1500)), 16'($urandom_range(235, 600)),
              16'($urandom_range(500, 5000)), 16'($urandom_range(1000, 8000)), 150);
    run_phase(16'($urandom_range(200, 1500)), 16'($urandom_range(235, 600)),
              16'($urandom_range(500, 5000)), 16'($urandom_range(1000, 8000)), 150);
    wait_idle();
    quiet_tail = 1'b1;
    run_phase(16'(hrpd_pkg::NOISE_FLOOR_RST), hrpd_pkg::MIN_INTERVAL_RST,
              hrpd_pkg::MAX_HOLD_RST, hrpd_pkg::INACTIVITY_RST, 240);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rate_expected.size() != 0) begin
      $display("%0t: %0d results expected, actual none", $time, rate_expected.size());
      mismatches++;
    end

    $display("Checked %0d results for %0d samples, %0d of them beats.",
             results_checked, samples_sent, beats_seen);
    $display("Ran %0d register settings and one %0d-cycle output hold.",
             settings_used, LONG_HOLD);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hrpd_pkg.sv
rtl/heart_rate_peak_detector.sv
dv/heart_rate_peak_detector_test.sv
